// ----- src/gha_pkg.sv -----
// Shared types and constants of the generational handle allocator.
// Holds the slot geometry, operation codes, controller states and the
// command and status structs; depends on nothing else.
package gha_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int VER_W      = 16;
    localparam int IN_IDX_W   = 8;
    localparam int GRP_SIZE   = 8;
    localparam int GRP_COUNT  = SLOT_COUNT / GRP_SIZE;
    localparam int GRP_W      = $clog2(GRP_SIZE);
    localparam int GSEL_W     = $clog2(GRP_COUNT);
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;

    localparam logic [VER_W-1:0] VER_INIT = VER_W'(1);

    typedef enum logic [1:0] {
        MODE_ALLOC    = 2'd0,
        MODE_FREE     = 2'd1,
        MODE_CHECK    = 2'd2,
        MODE_FREE_ALL = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP_RD,
        ST_SWEEP_WR,
        ST_RESOLVE
    } state_t;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic sweep_rd;
        logic sweep_wr;
        logic resolve;
    } cmd_t;

    typedef struct packed {
        logic req_free_all;
        logic sweep_last;
        logic out_ready;
    } status_t;

endpackage

// ----- src/gha_ctrl.sv -----
// Controller of the handle allocator: sequences lookup, free-all sweep and
// result delivery. Depends on gha_pkg.
module gha_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  gha_pkg::status_t status,
    output gha_pkg::cmd_t    cmd
);

    gha_pkg::state_t state_reg;
    gha_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gha_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = status.req_free_all ? gha_pkg::ST_SWEEP_RD
                                                     : gha_pkg::ST_LOOKUP;
                end
            end
            gha_pkg::ST_LOOKUP:   state_next = gha_pkg::ST_RESOLVE;
            gha_pkg::ST_SWEEP_RD: state_next = gha_pkg::ST_SWEEP_WR;
            gha_pkg::ST_SWEEP_WR:
            begin
                state_next = status.sweep_last ? gha_pkg::ST_RESOLVE
                                               : gha_pkg::ST_SWEEP_RD;
            end
            gha_pkg::ST_RESOLVE:
            begin
                if (status.out_ready)
                begin
                    state_next = gha_pkg::ST_IDLE;
                end
            end
            default:              state_next = gha_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            gha_pkg::ST_LOOKUP:   cmd.lookup   = 1'b1;
            gha_pkg::ST_SWEEP_RD: cmd.sweep_rd = 1'b1;
            gha_pkg::ST_SWEEP_WR: cmd.sweep_wr = 1'b1;
            gha_pkg::ST_RESOLVE:  cmd.resolve  = status.out_ready;
            default:              cmd          = '0;
        endcase
    end

endmodule

// ----- src/gha_datapath.sv -----
// Datapath of the handle allocator: use bits, version memory, free-slot
// search tree, sweep counter and result register. Depends on gha_pkg.
module gha_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  gha_pkg::cmd_t                cmd,
    output gha_pkg::status_t             status,
    input  gha_pkg::mode_t               in_mode,
    input  logic [gha_pkg::IN_IDX_W-1:0] in_index,
    input  logic [gha_pkg::VER_W-1:0]    in_version,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gha_pkg::IDX_W-1:0]    out_index,
    output logic [gha_pkg::VER_W-1:0]    out_version,
    output logic                         out_ok
);

    logic [gha_pkg::VER_W-1:0]      ver_mem [gha_pkg::SLOT_COUNT];
    logic [gha_pkg::VER_W-1:0]      rdata_reg;

    logic [gha_pkg::SLOT_COUNT-1:0] used_reg;
    logic [gha_pkg::SLOT_COUNT-1:0] vwr_reg;

    gha_pkg::mode_t                 mode_reg;
    logic [gha_pkg::IN_IDX_W-1:0]   idx_reg;
    logic [gha_pkg::VER_W-1:0]      hver_reg;

    logic [gha_pkg::GRP_COUNT-1:0]  grp_any;
    logic [gha_pkg::GRP_W-1:0]      grp_low     [gha_pkg::GRP_COUNT];
    logic [gha_pkg::GRP_COUNT-1:0]  grp_any_reg;
    logic [gha_pkg::GRP_W-1:0]      grp_low_reg [gha_pkg::GRP_COUNT];

    logic [gha_pkg::GSEL_W-1:0]     gsel;
    logic [gha_pkg::IDX_W-1:0]      alloc_idx;
    logic [gha_pkg::IDX_W-1:0]      lookup_addr;
    logic [gha_pkg::IDX_W-1:0]      addr_reg;
    logic                           found_reg;
    logic [gha_pkg::IDX_W-1:0]      cnt_reg;

    logic [gha_pkg::IDX_W-1:0]      cur_addr;
    logic [gha_pkg::VER_W-1:0]      cur_ver;
    logic                           in_range;
    logic                           mem_we;

    logic                           res_ok;
    logic [gha_pkg::IDX_W-1:0]      res_index;
    logic [gha_pkg::VER_W-1:0]      res_version;

    logic                           out_valid_reg;

    always_comb
    begin
        for (int g = 0; g < gha_pkg::GRP_COUNT; g++)
        begin
            grp_any[g] = 1'b0;
            grp_low[g] = '0;
            for (int k = gha_pkg::GRP_SIZE - 1; k >= 0; k--)
            begin
                if (!used_reg[g * gha_pkg::GRP_SIZE + k])
                begin
                    grp_any[g] = 1'b1;
                    grp_low[g] = gha_pkg::GRP_W'(k);
                end
            end
        end
    end

    always_comb
    begin
        gsel = '0;
        for (int g = gha_pkg::GRP_COUNT - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                gsel = gha_pkg::GSEL_W'(g);
            end
        end
    end

    assign alloc_idx   = {gsel, grp_low_reg[gsel]};
    assign lookup_addr = (mode_reg == gha_pkg::MODE_ALLOC) ? alloc_idx
                                                           : idx_reg[gha_pkg::IDX_W-1:0];
    assign in_range    = idx_reg < gha_pkg::IN_IDX_W'(gha_pkg::SLOT_COUNT);
    assign cur_addr    = cmd.sweep_wr ? cnt_reg : addr_reg;
    assign cur_ver     = vwr_reg[cur_addr] ? rdata_reg : gha_pkg::VER_INIT;
    assign mem_we      = (cmd.resolve && (mode_reg == gha_pkg::MODE_FREE) && in_range)
                      || (cmd.sweep_wr && used_reg[cnt_reg]);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg    <= in_mode;
            idx_reg     <= in_index;
            hver_reg    <= in_version;
            grp_any_reg <= grp_any;
            grp_low_reg <= grp_low;
        end
        if (cmd.lookup)
        begin
            addr_reg  <= lookup_addr;
            found_reg <= |grp_any_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ver_mem[cur_addr] <= cur_ver + gha_pkg::VER_W'(1);
        end
        if (cmd.lookup)
        begin
            rdata_reg <= ver_mem[lookup_addr];
        end
        else if (cmd.sweep_rd)
        begin
            rdata_reg <= ver_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            vwr_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                vwr_reg[cur_addr]  <= 1'b1;
                used_reg[cur_addr] <= 1'b0;
            end
            else if (cmd.resolve && (mode_reg == gha_pkg::MODE_ALLOC) && found_reg)
            begin
                used_reg[addr_reg] <= 1'b1;
            end
            if (cmd.accept)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.sweep_wr)
            begin
                cnt_reg <= cnt_reg + gha_pkg::IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        res_ok      = 1'b0;
        res_index   = '0;
        res_version = '0;
        case (mode_reg)
            gha_pkg::MODE_ALLOC:
            begin
                res_ok = found_reg;
                if (found_reg)
                begin
                    res_index   = addr_reg;
                    res_version = cur_ver;
                end
            end
            gha_pkg::MODE_FREE:     res_ok = in_range;
            gha_pkg::MODE_CHECK:
            begin
                res_ok = in_range && used_reg[addr_reg] && (cur_ver == hver_reg);
            end
            gha_pkg::MODE_FREE_ALL: res_ok = 1'b1;
            default:                res_ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.resolve)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            out_index   <= res_index;
            out_version <= res_version;
            out_ok      <= res_ok;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status.out_ready    = !out_valid_reg || out_ready;
    assign status.sweep_last   = cnt_reg == gha_pkg::IDX_W'(gha_pkg::SLOT_COUNT - 1);
    assign status.req_free_all = in_mode == gha_pkg::MODE_FREE_ALL;

endmodule

// ----- src/generational_handle_allocator_core.sv -----
// Top level of the generational handle allocator.
// Joins the controller and the datapath; depends on gha_pkg, gha_ctrl and gha_datapath.
//
// Usage: each request arrives on the s_ channel with its operation in s_tuser
// (allocate, free, check, free all) and the slot index and handle version in
// s_tdata. Exactly one result leaves on the m_ channel per request.
// Allocate, free and check pass through the lookup state and then the resolve
// state, which loads the result register; one request is in flight at a time,
// so a new request is taken only after the last one has left the resolve state.
// Free all walks every slot through the single port of the version memory, in
// a read state and a write state per slot, and then loads the result register
// in the resolve state. The free-slot search is a two-level tree registered
// between its levels.
// After reset no slot is in use and every version reads as one, with no
// clearing pass. A result waits in its output register while the receiver
// stalls; the next request is still accepted and processed, and it waits at
// the result stage until the register is taken.
module generational_handle_allocator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from low: slot_index[7:0], handle_version[23:8].
    input  logic [gha_pkg::S_TDATA_W-1:0] s_tdata,
    // Bits from low: mode[1:0].
    input  logic [gha_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from low: out_index[5:0], out_version[21:6], ok[22], zero pad[23].
    output logic [gha_pkg::M_TDATA_W-1:0] m_tdata
);

    gha_pkg::cmd_t                 cmd;
    gha_pkg::status_t              status;
    logic [gha_pkg::IDX_W-1:0]     out_index;
    logic [gha_pkg::VER_W-1:0]     out_version;
    logic                          out_ok;

    gha_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    gha_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_mode     (gha_pkg::mode_t'(s_tuser)),
        .in_index    (s_tdata[gha_pkg::IN_IDX_W-1:0]),
        .in_version  (s_tdata[gha_pkg::IN_IDX_W +: gha_pkg::VER_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (out_index),
        .out_version (out_version),
        .out_ok      (out_ok)
    );

    assign m_tdata = {1'b0, out_ok, out_version, out_index};

endmodule

// ----- src/gha_checker.sv -----
// Port-level checker for the generational handle allocator, bound to the top level.
// Depends on generational_handle_allocator_core and gha_pkg.
module gha_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gha_pkg::M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed or dropped while stalled.");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Second request accepted while one is in flight.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[22] |-> m_tdata[21:0] == 22'd0)
        else $error("Failed result carries a nonzero index or version.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("Result appeared with no request in flight.");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_allocator_core.
// Sends allocate, free, check and free-all requests on the slave stream and checks every
// reply against its slot-table copy or a scripted value; depends on gha_pkg and the core.
module testbench;

    localparam int LIMIT = 3_000_000;

    typedef struct packed {
        logic [gha_pkg::IDX_W-1:0] index;
        logic [gha_pkg::VER_W-1:0] version;
        logic                      ok;
    } reply_t;

    typedef struct packed {
        gha_pkg::mode_t op;
        logic [7:0]     idx;
        logic [15:0]    ver;
        logic           typed;
        reply_t         want;
    } row_t;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [gha_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [gha_pkg::S_TUSER_W-1:0]  s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [gha_pkg::M_TDATA_W-1:0]  m_tdata;

    logic                           slot_live [gha_pkg::SLOT_COUNT];
    logic [gha_pkg::VER_W-1:0]      slot_gen [gha_pkg::SLOT_COUNT];
    reply_t                         pending_replies [$];
    int                             failures = 0;
    int                             cycles = 0;
    bit                             quiet = 1'b0;
    mix_t                           mix = MIX_EVEN;

    row_t script [0:24] = '{
        '{gha_pkg::MODE_CHECK,    8'd0,   16'd1,     1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_ALLOC,    8'hFF,  16'hFFFF,  1'b1, '{6'd0, 16'd1, 1'b1}},
        '{gha_pkg::MODE_ALLOC,    8'h00,  16'h0000,  1'b1, '{6'd1, 16'd1, 1'b1}},
        '{gha_pkg::MODE_CHECK,    8'd0,   16'd1,     1'b1, '{6'd0, 16'd0, 1'b1}},
        '{gha_pkg::MODE_CHECK,    8'd0,   16'hFFFF,  1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_CHECK,    8'd1,   16'd0,     1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_CHECK,    8'd64,  16'd1,     1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_CHECK,    8'd255, 16'hFFFF,  1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_FREE,     8'd255, 16'hFFFF,  1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_FREE,     8'd64,  16'd0,     1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_FREE,     8'd0,   16'd0,     1'b1, '{6'd0, 16'd0, 1'b1}},
        '{gha_pkg::MODE_CHECK,    8'd0,   16'd1,     1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_CHECK,    8'd0,   16'd2,     1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_ALLOC,    8'hAA,  16'h5555,  1'b0, '0},
        '{gha_pkg::MODE_CHECK,    8'd0,   16'd2,     1'b0, '0},
        '{gha_pkg::MODE_FREE,     8'd63,  16'hFFFF,  1'b1, '{6'd0, 16'd0, 1'b1}},
        '{gha_pkg::MODE_ALLOC,    8'h55,  16'hAAAA,  1'b1, '{6'd2, 16'd1, 1'b1}},
        '{gha_pkg::MODE_FREE_ALL, 8'hFF,  16'hFFFF,  1'b1, '{6'd0, 16'd0, 1'b1}},
        '{gha_pkg::MODE_CHECK,    8'd1,   16'd1,     1'b1, '{6'd0, 16'd0, 1'b0}},
        '{gha_pkg::MODE_ALLOC,    8'h00,  16'h0000,  1'b0, '0},
        '{gha_pkg::MODE_ALLOC,    8'h00,  16'h0000,  1'b0, '0},
        '{gha_pkg::MODE_ALLOC,    8'h00,  16'h0000,  1'b0, '0},
        '{gha_pkg::MODE_ALLOC,    8'h00,  16'h0000,  1'b0, '0},
        '{gha_pkg::MODE_FREE_ALL, 8'h00,  16'h0000,  1'b1, '{6'd0, 16'd0, 1'b1}},
        '{gha_pkg::MODE_CHECK,    8'd63,  16'd2,     1'b1, '{6'd0, 16'd0, 1'b0}}
    };

    generational_handle_allocator_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic reply_t handle_outcome(gha_pkg::mode_t op, logic [7:0] idx,
                                              logic [15:0] ver);
        reply_t r;
        r = '0;
        case (op)
            gha_pkg::MODE_ALLOC:
            begin
                for (int i = 0; i < gha_pkg::SLOT_COUNT; i++)
                begin
                    if (!slot_live[i])
                    begin
                        slot_live[i] = 1'b1;
                        r.index = gha_pkg::IDX_W'(i);
                        r.version = slot_gen[i];
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            gha_pkg::MODE_FREE:
            begin
                if (int'(idx) < gha_pkg::SLOT_COUNT)
                begin
                    slot_gen[idx] = slot_gen[idx] + 16'd1;
                    slot_live[idx] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            gha_pkg::MODE_CHECK:
            begin
                if (int'(idx) < gha_pkg::SLOT_COUNT && slot_live[idx] && slot_gen[idx] == ver)
                    r.ok = 1'b1;
            end
            gha_pkg::MODE_FREE_ALL:
            begin
                for (int i = 0; i < gha_pkg::SLOT_COUNT; i++)
                begin
                    if (slot_live[i])
                    begin
                        slot_gen[i] = slot_gen[i] + 16'd1;
                        slot_live[i] = 1'b0;
                    end
                end
                r.ok = 1'b1;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic int find_live();
        int start;
        start = $urandom_range(0, gha_pkg::SLOT_COUNT - 1);
        for (int k = 0; k < gha_pkg::SLOT_COUNT; k++)
        begin
            if (slot_live[(start + k) % gha_pkg::SLOT_COUNT])
                return (start + k) % gha_pkg::SLOT_COUNT;
        end
        return -1;
    endfunction

    task automatic issue(input gha_pkg::mode_t op, input logic [7:0] idx,
                         input logic [15:0] ver, input logic typed, input reply_t want);
        int gap;
        reply_t r;
        gap = idle_draw();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {ver, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = handle_outcome(op, idx, ver);
        pending_replies.push_back(typed ? want : r);
    endtask

    task automatic pick_request(output gha_pkg::mode_t op, output logic [7:0] idx,
                                output logic [15:0] ver);
        int r;
        int r2;
        int s;
        int a_cut;
        int c_cut;
        int f_cut;
        r = $urandom_range(0, 99);
        r2 = $urandom_range(0, 99);
        idx = 8'($urandom_range(0, 255));
        ver = 16'($urandom_range(0, 65535));
        s = find_live();
        case (mix)
            MIX_FILL:  begin a_cut = 75; c_cut = 90; f_cut = 98; end
            MIX_DRAIN: begin a_cut = 15; c_cut = 40; f_cut = 97; end
            default:   begin a_cut = 35; c_cut = 65; f_cut = 96; end
        endcase
        if (r < a_cut)
            op = gha_pkg::MODE_ALLOC;
        else if (r < c_cut)
        begin
            op = gha_pkg::MODE_CHECK;
            if (s >= 0 && r2 < 70)
            begin
                idx = 8'(s);
                ver = slot_gen[s];
            end
            else if (s >= 0 && r2 < 85)
            begin
                idx = 8'(s);
                ver = slot_gen[s] + ((r2 % 2) ? 16'd1 : 16'hFFFF);
            end
        end
        else if (r < f_cut)
        begin
            op = gha_pkg::MODE_FREE;
            if (r2 < 85)
                idx = (s >= 0) ? 8'(s) : 8'($urandom_range(0, gha_pkg::SLOT_COUNT - 1));
        end
        else
            op = gha_pkg::MODE_FREE_ALL;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin : watch_replies
        reply_t want;
        reply_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.index = m_tdata[5:0];
            seen.version = m_tdata[21:6];
            seen.ok = m_tdata[22];
            if (pending_replies.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected reply: index %0d version %0d ok %0b",
                             seen.index, seen.version, seen.ok);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (want != seen)
                begin
                    failures++;
                    if (failures <= 10)
                        $display({"mismatch: expected index %0d version %0d ok %0b, ",
                                  "got index %0d version %0d ok %0b"},
                                 want.index, want.version, want.ok,
                                 seen.index, seen.version, seen.ok);
                end
            end
        end
    end

    initial
    begin : receiver
        int n;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            n = idle_draw();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : sender
        gha_pkg::mode_t op;
        logic [7:0] idx;
        logic [15:0] ver;
        int episode_left;
        episode_left = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= gha_pkg::MODE_ALLOC;
        for (int i = 0; i < gha_pkg::SLOT_COUNT; i++)
        begin
            slot_live[i] = 1'b0;
            slot_gen[i] = gha_pkg::VER_INIT;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            issue(script[i].op, script[i].idx, script[i].ver, script[i].typed, script[i].want);

        for (int k = 0; k < 1650; k++)
        begin
            if (episode_left == 0)
            begin
                mix = mix_t'($urandom_range(0, 2));
                episode_left = $urandom_range(40, 120);
            end
            episode_left--;
            if ($urandom_range(0, 79) == 0)
                quiet = !quiet;
            pick_request(op, idx, ver);
            issue(op, idx, ver, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
